>>> hw/rtl/cdd_pkg.sv
// Shared constants, widths and the month table for the calendar date difference block.
// No dependencies; imported by every module of the block.
package cdd_pkg;

    localparam int YEAR_W  = 14;
    localparam int MONTH_W = 4;
    localparam int DAY_W   = 5;
    localparam int SECS_W  = 17;

    localparam int DNUM_W  = 24;   // signed day number; y=0, m=0, d=0 gives -1
    localparam int DDIFF_W = 23;
    localparam int SDIFF_W = 40;
    localparam int SSAME_W = SECS_W + 1;

    localparam int DAYS_PER_YEAR = 365;
    localparam int SECS_PER_DAY  = 86400;

    // floor(x/25) == (x*1311) >> 15 for x < 4681, which covers every quotient input here
    localparam int RECIP25       = 1311;
    localparam int RECIP25_SHIFT = 15;
    localparam int RECIP25_W     = 11;

    localparam logic [MONTH_W-1:0] MONTH_FEB = 4'd2;
    localparam logic [MONTH_W-1:0] MONTH_DEC = 4'd12;

    // days before the first of the month in a common year; month zero counts as none
    function automatic logic [8:0] days_before_month(input logic [MONTH_W-1:0] m);
        logic [8:0] v;
        unique case (m)
            4'd0, 4'd1: v = 9'd0;
            4'd2:       v = 9'd31;
            4'd3:       v = 9'd59;
            4'd4:       v = 9'd90;
            4'd5:       v = 9'd120;
            4'd6:       v = 9'd151;
            4'd7:       v = 9'd181;
            4'd8:       v = 9'd212;
            4'd9:       v = 9'd243;
            4'd10:      v = 9'd273;
            4'd11:      v = 9'd304;
            default:    v = 9'd334;   // December and anything above
        endcase
        return v;
    endfunction

endpackage

>>> hw/rtl/cdd_date_num.sv
// Two-stage conversion of one Gregorian date into a signed day number counted from 1 Jan year 0.
// Depends on cdd_pkg.
module cdd_date_num import cdd_pkg::*; (
    input  logic                     i_clk,
    input  logic                     i_en,
    input  logic [YEAR_W-1:0]        i_year,
    input  logic [MONTH_W-1:0]       i_month,
    input  logic [DAY_W-1:0]         i_day,
    output logic signed [DNUM_W-1:0] o_day_num
);

    // stage 1: year products, quotients by reciprocal multiply, month offset
    logic [22:0] n_y365;
    logic [12:0] n_q4;
    logic [8:0]  n_q100;
    logic [5:0]  n_q400;
    logic [11:0] n_yq4;
    logic [7:0]  n_ql4;
    logic [9:0]  n_yq16;
    logic [5:0]  n_ql16;
    logic [9:0]  n_dpart;
    logic        n_after_feb;

    logic [YEAR_W:0]   w_y99, w_y399, w_y3;
    logic [12:0]       w_d100;
    logic [10:0]       w_d400;
    logic [23:0]       w_p100, w_p400, w_pl4, w_pl16;
    logic [MONTH_W-1:0] w_mc;

    always_comb begin
        w_y3   = {1'b0, i_year} + 15'd3;
        w_y99  = {1'b0, i_year} + 15'd99;
        w_y399 = {1'b0, i_year} + 15'd399;
        w_d100 = w_y99[YEAR_W:2];
        w_d400 = w_y399[YEAR_W:4];
        w_p100 = 24'(w_d100) * 24'(RECIP25);
        w_p400 = 24'(w_d400) * 24'(RECIP25);
        w_pl4  = 24'(i_year[YEAR_W-1:2]) * 24'(RECIP25);
        w_pl16 = 24'(i_year[YEAR_W-1:4]) * 24'(RECIP25);

        n_y365 = 23'(i_year) * 23'(DAYS_PER_YEAR);
        n_q4   = w_y3[YEAR_W:2];
        n_q100 = w_p100[RECIP25_SHIFT +: 9];
        n_q400 = w_p400[RECIP25_SHIFT +: 6];
        n_yq4  = i_year[YEAR_W-1:2];
        n_ql4  = w_pl4[RECIP25_SHIFT +: 8];
        n_yq16 = i_year[YEAR_W-1:4];
        n_ql16 = w_pl16[RECIP25_SHIFT +: 6];

        w_mc        = (i_month > MONTH_DEC) ? MONTH_DEC : i_month;
        n_dpart     = 10'(days_before_month(w_mc)) + 10'(i_day);
        n_after_feb = (w_mc > MONTH_FEB);
    end

    logic [22:0] r_y365;
    logic [12:0] r_q4;
    logic [8:0]  r_q100;
    logic [5:0]  r_q400;
    logic [11:0] r_yq4;
    logic [7:0]  r_ql4;
    logic [9:0]  r_yq16;
    logic [5:0]  r_ql16;
    logic [9:0]  r_dpart;
    logic        r_after_feb;
    logic [3:0]  r_ylo;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_y365      <= n_y365;
            r_q4        <= n_q4;
            r_q100      <= n_q100;
            r_q400      <= n_q400;
            r_yq4       <= n_yq4;
            r_ql4       <= n_ql4;
            r_yq16      <= n_yq16;
            r_ql16      <= n_ql16;
            r_dpart     <= n_dpart;
            r_after_feb <= n_after_feb;
            r_ylo       <= i_year[3:0];
        end
    end

    // stage 2: leap rule from remainders, then sum
    logic [11:0] w_r4;     // (y/4) mod 25, zero iff y mod 100 == 0 given y mod 4 == 0
    logic [9:0]  w_r16;
    logic        w_leap;
    logic [12:0] w_leaps;
    logic signed [DNUM_W-1:0] n_day_num;

    always_comb begin
        w_r4    = r_yq4 - 12'(r_ql4) * 12'd25;
        w_r16   = r_yq16 - 10'(r_ql16) * 10'd25;
        w_leap  = ((r_ylo[1:0] == 2'd0) && (w_r4 != 12'd0))
               || ((r_ylo == 4'd0) && (w_r16 == 10'd0));
        w_leaps = r_q4 - 13'(r_q100) + 13'(r_q400);
        n_day_num = $signed(DNUM_W'(r_y365)) + $signed(DNUM_W'(w_leaps))
                  + $signed(DNUM_W'(r_dpart))
                  + $signed(DNUM_W'(r_after_feb && w_leap)) - DNUM_W'(1);
    end

    logic signed [DNUM_W-1:0] r_day_num;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_day_num <= n_day_num;
        end
    end

    assign o_day_num = r_day_num;

endmodule

>>> hw/rtl/cdd_diff.sv
// Day-number subtraction and the seconds result (whole days or same-date seconds), two stages.
// Depends on cdd_pkg.
module cdd_diff import cdd_pkg::*; (
    input  logic                      i_clk,
    input  logic                      i_en,
    input  logic signed [DNUM_W-1:0]  i_num_a,
    input  logic signed [DNUM_W-1:0]  i_num_b,
    input  logic                      i_same,
    input  logic signed [SSAME_W-1:0] i_sec_same,
    output logic signed [DDIFF_W-1:0] o_day_diff,
    output logic signed [SDIFF_W-1:0] o_sec_diff
);

    // stage 3: day difference, full width so the seconds product sees it unwrapped
    logic signed [DNUM_W-1:0]  r_days;
    logic                      r_same;
    logic signed [SSAME_W-1:0] r_sec_same;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_days     <= i_num_b - i_num_a;
            r_same     <= i_same;
            r_sec_same <= i_sec_same;
        end
    end

    // stage 4: days * 86400 or same-date seconds
    logic signed [DNUM_W+17:0] w_prod;
    logic signed [SDIFF_W-1:0] n_sec_diff;

    always_comb begin
        w_prod     = r_days * $signed(18'(SECS_PER_DAY));
        n_sec_diff = r_same ? SDIFF_W'(r_sec_same) : w_prod[SDIFF_W-1:0];
    end

    logic signed [DDIFF_W-1:0] r_day_diff;
    logic signed [SDIFF_W-1:0] r_sec_diff;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_day_diff <= r_days[DDIFF_W-1:0];
            r_sec_diff <= n_sec_diff;
        end
    end

    assign o_day_diff = r_day_diff;
    assign o_sec_diff = r_sec_diff;

endmodule

>>> hw/rtl/calendar_date_difference.sv
// Top level: two date converters, difference stage and the valid pipeline with stall handling.
// Depends on cdd_pkg, cdd_date_num and cdd_diff.
//
//   channel   valid     stall     payload
//   input     i_valid   o_stall   i_year_a .. i_secs_b
//   output    o_valid   i_stall   o_day_diff, o_sec_diff
//
// Four register stages. One transaction per cycle while the pipeline is not held;
// it is a single-pass pipeline (no shared unit). Reset clears the valid bits only.
// The whole pipeline holds while the output register has a result and i_stall is
// high; o_stall follows that condition.
module calendar_date_difference import cdd_pkg::*; (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_valid,
    output logic                      o_stall,
    input  logic [YEAR_W-1:0]         i_year_a,
    input  logic [MONTH_W-1:0]        i_month_a,
    input  logic [DAY_W-1:0]          i_day_a,
    input  logic [SECS_W-1:0]         i_secs_a,
    input  logic [YEAR_W-1:0]         i_year_b,
    input  logic [MONTH_W-1:0]        i_month_b,
    input  logic [DAY_W-1:0]          i_day_b,
    input  logic [SECS_W-1:0]         i_secs_b,
    output logic                      o_valid,
    input  logic                      i_stall,
    output logic signed [DDIFF_W-1:0] o_day_diff,
    output logic signed [SDIFF_W-1:0] o_sec_diff
);

    logic [3:0] r_valid;
    logic       w_en;

    assign w_en    = !(r_valid[3] && i_stall);
    assign o_stall = !w_en;
    assign o_valid = r_valid[3];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else if (w_en) begin
            r_valid <= {r_valid[2:0], i_valid};
        end
    end

    // same-date flag and seconds difference, delayed to meet the day numbers
    logic                      n_same;
    logic signed [SSAME_W-1:0] n_sec_same;
    logic [1:0]                r_same;
    logic signed [SSAME_W-1:0] r_sec_same [2];

    always_comb begin
        n_same     = (i_year_a == i_year_b) && (i_month_a == i_month_b) && (i_day_a == i_day_b);
        n_sec_same = $signed({1'b0, i_secs_b}) - $signed({1'b0, i_secs_a});
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_same        <= {r_same[0], n_same};
            r_sec_same[0] <= n_sec_same;
            r_sec_same[1] <= r_sec_same[0];
        end
    end

    logic signed [DNUM_W-1:0] w_num_a, w_num_b;

    cdd_date_num u_num_a (
        .i_clk     (i_clk),
        .i_en      (w_en),
        .i_year    (i_year_a),
        .i_month   (i_month_a),
        .i_day     (i_day_a),
        .o_day_num (w_num_a)
    );

    cdd_date_num u_num_b (
        .i_clk     (i_clk),
        .i_en      (w_en),
        .i_year    (i_year_b),
        .i_month   (i_month_b),
        .i_day     (i_day_b),
        .o_day_num (w_num_b)
    );

    cdd_diff u_diff (
        .i_clk      (i_clk),
        .i_en       (w_en),
        .i_num_a    (w_num_a),
        .i_num_b    (w_num_b),
        .i_same     (r_same[1]),
        .i_sec_same (r_sec_same[1]),
        .o_day_diff (o_day_diff),
        .o_sec_diff (o_sec_diff)
    );

endmodule
